// ----- src/xrtf_pkg.sv -----
package xrtf_pkg;

  // Frame size limit; offsets are 16 bits wide, so the usable limit is capped at 65536
  localparam int unsigned MAX_FRAME_BYTES = 65536;
  localparam int unsigned OFFSET_LIMIT    = (MAX_FRAME_BYTES > 65536) ? 65536 : MAX_FRAME_BYTES;
  localparam logic [15:0] LAST_OFFSET     = 16'(OFFSET_LIMIT - 1);

  // Per-byte status codes
  localparam logic [1:0] ST_OUTSIDE = 2'd0;
  localparam logic [1:0] ST_FRAME   = 2'd1;
  localparam logic [1:0] ST_LAST    = 2'd2;
  localparam logic [1:0] ST_ERROR   = 2'd3;

  // Root kinds
  localparam logic [1:0] RK_REQUEST = 2'd0;
  localparam logic [1:0] RK_REPLY   = 2'd1;
  localparam logic [1:0] RK_EVENT   = 2'd2;

  // Characters of interest
  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;

  typedef struct packed {
    logic       restart;
    logic [7:0] data_byte;
  } item_t;

  typedef struct packed {
    logic [15:0] frame_offset;
    logic [1:0]  root_kind;
    logic [1:0]  status;
    logic [7:0]  byte_out;
  } result_t;

  // Length of a root name
  function automatic logic [3:0] root_len(input logic [1:0] kind);
    logic [3:0] len;
    len = 4'd5;
    if (kind == RK_REQUEST) len = 4'd7;
    return len;
  endfunction

  // Character idx of a root name ("Request", "Reply", "Event")
  function automatic logic [7:0] root_char(input logic [1:0] kind, input logic [2:0] idx);
    logic [7:0] ch;
    ch = 8'h00;
    case (kind)
      RK_REQUEST: begin
        case (idx)
          3'd0: ch = "R";
          3'd1: ch = "e";
          3'd2: ch = "q";
          3'd3: ch = "u";
          3'd4: ch = "e";
          3'd5: ch = "s";
          3'd6: ch = "t";
          default: ch = 8'h00;
        endcase
      end
      RK_REPLY: begin
        case (idx)
          3'd0: ch = "R";
          3'd1: ch = "e";
          3'd2: ch = "p";
          3'd3: ch = "l";
          3'd4: ch = "y";
          default: ch = 8'h00;
        endcase
      end
      RK_EVENT: begin
        case (idx)
          3'd0: ch = "E";
          3'd1: ch = "v";
          3'd2: ch = "e";
          3'd3: ch = "n";
          3'd4: ch = "t";
          default: ch = 8'h00;
        endcase
      end
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  // Character expected at position m of the closing tag "</name>"
  function automatic logic [7:0] close_char(input logic [1:0] kind, input logic [3:0] m);
    logic [7:0] ch;
    logic [3:0] pos;
    pos = m - 4'd2;
    if (m == 4'd0) ch = CH_LT;
    else if (m == 4'd1) ch = CH_SLASH;
    else if (m < root_len(kind) + 4'd2) ch = root_char(kind, pos[2:0]);
    else ch = CH_GT;
    return ch;
  endfunction

endpackage

// ----- src/xml_root_tag_framer.sv -----
// A byte accepted into the input register moves on to the result register, behind
// the per-byte frame update, once that register has room (empty or being drained);
// its report transaction then stays on out_tvalid until out_tready takes it.
// Throughput: one byte per cycle unless out_tready stalls; frame state updates once per byte.
// Reset (rst_n low, synchronous): both stages empty, frame state back to skipping
// whitespace with all root candidates live and all counters at zero.
module xml_root_tag_framer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic [0:0]  in_tuser,   // [0] restart
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [7:0] byte_out, [23:8] frame_offset
  output logic [3:0]  out_tuser   // [1:0] status, [3:2] root_kind
);
  import xrtf_pkg::*;

  item_t   in_item, item;
  result_t res, out_res;
  logic    item_valid, fire;

  assign in_item.data_byte = in_tdata;
  assign in_item.restart   = in_tuser[0];

  // Input register
  xrtf_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_item    (in_item),
    .item_valid (item_valid),
    .item_take  (fire),
    .item       (item)
  );

  // Frame detection
  xrtf_parser u_parser (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (fire),
    .item  (item),
    .res   (res)
  );

  // Result register
  xrtf_out_reg u_out_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (item_valid),
    .fire       (fire),
    .res        (res),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_res    (out_res)
  );

  assign out_tdata = {out_res.frame_offset, out_res.byte_out};
  assign out_tuser = {out_res.root_kind, out_res.status};

endmodule

// ----- src/xrtf_in_reg.sv -----
module xrtf_in_reg (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  xrtf_pkg::item_t in_item,
  output logic           item_valid,
  input  logic           item_take,
  output xrtf_pkg::item_t item
);
  import xrtf_pkg::*;

  logic  valid_r, valid_nxt;
  item_t item_r;
  logic  accept;

  // Slot frees when empty or when its item moves on this cycle
  assign in_ready  = !valid_r || item_take;
  assign accept    = in_valid && in_ready;
  assign valid_nxt = accept ? 1'b1 : (item_take ? 1'b0 : valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Payload register
  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= in_item;
    end
  end

  assign item_valid = valid_r;
  assign item       = item_r;

endmodule

// ----- src/xrtf_parser.sv -----
module xrtf_parser (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              fire,
  input  xrtf_pkg::item_t   item,
  output xrtf_pkg::result_t res
);
  import xrtf_pkg::*;

  typedef enum logic [1:0] {
    PH_SKIP = 2'd0,
    PH_ROOT = 2'd1,
    PH_BODY = 2'd2
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic [2:0]  cand_r, cand_nxt;
  logic [1:0]  chosen_r, chosen_nxt;
  logic [3:0]  cm_r, cm_nxt;
  logic [15:0] pos_r, pos_nxt;

  // Frame state after an optional restart
  logic [1:0]  eff_phase;
  logic [2:0]  eff_cand;
  logic [1:0]  eff_chosen;
  logic [3:0]  eff_cm;
  logic [15:0] eff_pos;

  logic [16:0] next_pos;
  logic [7:0]  b;
  logic        is_space, is_name_end;
  logic [2:0]  live, found;
  logic [2:0]  name_idx;
  logic [1:0]  body_kind;
  logic [3:0]  m, m_inc, len_b;

  assign b           = item.data_byte;
  assign is_space    = (b == CH_SPACE) || (b == CH_TAB) || (b == CH_CR) || (b == CH_LF);
  assign is_name_end = (b == CH_SPACE) || (b == CH_GT) || (b == CH_CR) || (b == CH_LF);

  always_comb begin
    if (item.restart) begin
      eff_phase  = PH_SKIP;
      eff_cand   = 3'b111;
      eff_chosen = RK_REQUEST;
      eff_cm     = 4'd0;
      eff_pos    = 16'd0;
    end else begin
      eff_phase  = phase_r;
      eff_cand   = cand_r;
      eff_chosen = chosen_r;
      eff_cm     = cm_r;
      eff_pos    = pos_r;
    end
  end

  assign next_pos = {1'b0, eff_pos} + 17'd1;
  assign name_idx = next_pos[2:0] - 3'd1;

  // Root name match, one lane per candidate
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      live[k]  = eff_cand[k] && (next_pos <= {13'd0, root_len(2'(k))})
                 && (b == root_char(2'(k), name_idx));
      found[k] = eff_cand[k] && (next_pos == {13'd0, root_len(2'(k))} + 17'd1)
                 && is_name_end;
    end
  end

  // Closing tag tracking
  assign body_kind = (eff_chosen == RK_EVENT || eff_chosen == RK_REPLY) ? eff_chosen
                                                                         : RK_REQUEST;
  assign len_b = root_len(body_kind);
  assign m     = (eff_cm > len_b + 4'd2) ? 4'd0 : eff_cm;
  assign m_inc = m + 4'd1;

  // Next state and result
  always_comb begin
    phase_nxt        = phase_t'(eff_phase);
    cand_nxt         = eff_cand;
    chosen_nxt       = eff_chosen;
    cm_nxt           = eff_cm;
    pos_nxt          = eff_pos;
    res.byte_out     = b;
    res.status       = ST_OUTSIDE;
    res.root_kind    = RK_REQUEST;
    res.frame_offset = 16'd0;

    unique case (eff_phase)
      PH_ROOT, PH_BODY: begin
        if (next_pos >= 17'(OFFSET_LIMIT)) begin
          // Frame too long
          res.status       = ST_ERROR;
          res.root_kind    = (eff_phase == PH_BODY) ? eff_chosen : RK_REQUEST;
          res.frame_offset = LAST_OFFSET;
          phase_nxt        = PH_SKIP;
          cand_nxt         = 3'b111;
          chosen_nxt       = RK_REQUEST;
          cm_nxt           = 4'd0;
          pos_nxt          = 16'd0;
        end else if (eff_phase == PH_ROOT) begin
          res.frame_offset = next_pos[15:0];
          pos_nxt          = next_pos[15:0];
          if (found != 3'b000) begin
            phase_nxt     = PH_BODY;
            chosen_nxt    = found[0] ? RK_REQUEST : (found[1] ? RK_REPLY : RK_EVENT);
            cand_nxt      = found[0] ? 3'b001 : (found[1] ? 3'b010 : 3'b100);
            cm_nxt        = 4'd0;
            res.status    = ST_FRAME;
            res.root_kind = found[0] ? RK_REQUEST : (found[1] ? RK_REPLY : RK_EVENT);
          end else if (live == 3'b000) begin
            // Unknown root
            res.status = ST_ERROR;
            phase_nxt  = PH_SKIP;
            cand_nxt   = 3'b111;
            chosen_nxt = RK_REQUEST;
            cm_nxt     = 4'd0;
            pos_nxt    = 16'd0;
          end else begin
            cand_nxt   = live;
            res.status = ST_FRAME;
          end
        end else begin
          res.frame_offset = next_pos[15:0];
          res.root_kind    = body_kind;
          pos_nxt          = next_pos[15:0];
          if (b == close_char(body_kind, m)) begin
            if (m_inc == len_b + 4'd3) begin
              res.status = ST_LAST;
              phase_nxt  = PH_SKIP;
              cand_nxt   = 3'b111;
              chosen_nxt = RK_REQUEST;
              cm_nxt     = 4'd0;
              pos_nxt    = 16'd0;
            end else begin
              res.status = ST_FRAME;
              cm_nxt     = m_inc;
            end
          end else begin
            res.status = ST_FRAME;
            cm_nxt     = (b == CH_LT) ? 4'd1 : 4'd0;
          end
        end
      end
      default: begin
        // Skipping; the unused phase code behaves the same
        phase_nxt = PH_SKIP;
        if (is_space) begin
          res.status = ST_OUTSIDE;
        end else if (b == CH_LT) begin
          phase_nxt  = PH_ROOT;
          cand_nxt   = 3'b111;
          chosen_nxt = RK_REQUEST;
          cm_nxt     = 4'd0;
          pos_nxt    = 16'd0;
          res.status = ST_FRAME;
        end else begin
          res.status = ST_ERROR;
          cand_nxt   = 3'b111;
          chosen_nxt = RK_REQUEST;
          cm_nxt     = 4'd0;
          pos_nxt    = 16'd0;
        end
      end
    endcase
  end

  // Frame state, updated as each transaction leaves for the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_SKIP;
      cand_r   <= 3'b111;
      chosen_r <= RK_REQUEST;
      cm_r     <= 4'd0;
      pos_r    <= 16'd0;
    end else if (fire) begin
      phase_r  <= phase_nxt;
      cand_r   <= cand_nxt;
      chosen_r <= chosen_nxt;
      cm_r     <= cm_nxt;
      pos_r    <= pos_nxt;
    end
  end

  // A confirmed root leaves exactly one candidate
  a_body_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_BODY) |-> $onehot(cand_r))
    else $error("body phase without a single root candidate");

  // Outside a frame the counters sit at zero
  a_skip_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_SKIP) |-> (pos_r == 16'd0 && cm_r == 4'd0))
    else $error("counters not cleared while skipping");

  // A last byte or an error always drops back to skipping
  a_end_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && (res.status == ST_LAST || res.status == ST_ERROR)) |=> (phase_r == PH_SKIP))
    else $error("frame end did not return to skipping");

  // Closing tag match never runs past the tag length
  a_cm_range: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_BODY) |-> (cm_r <= root_len(chosen_r) + 4'd2))
    else $error("closing tag position out of range");

endmodule

// ----- src/xrtf_out_reg.sv -----
module xrtf_out_reg (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              item_valid,
  output logic              fire,
  input  xrtf_pkg::result_t res,
  output logic              out_valid,
  input  logic              out_ready,
  output xrtf_pkg::result_t out_res
);
  import xrtf_pkg::*;

  logic    valid_r, valid_nxt;
  result_t res_r;
  logic    room;

  // Register can load when empty or being drained this cycle
  assign room      = !valid_r || out_ready;
  assign fire      = item_valid && room;
  assign valid_nxt = fire ? 1'b1 : (out_ready ? 1'b0 : valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (fire) begin
      res_r <= res;
    end
  end

  assign out_valid = valid_r;
  assign out_res   = res_r;

endmodule

// ----- tb/xrtf_frame_checker.sv -----
// Watches both channels of the framer, predicts the report for every accepted
// byte and compares each report transaction against the oldest prediction.
module xrtf_frame_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic [0:0]  in_tuser,   // [0] restart
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [23:0] out_tdata,  // [7:0] byte_out, [23:8] frame_offset
  input  logic [3:0]  out_tuser,  // [1:0] status, [3:2] root_kind
  output int          fail_count,
  output int          outstanding
);
  import xrtf_pkg::*;

  typedef enum logic [1:0] {
    SKIPPING  = 2'd0,
    ROOT_NAME = 2'd1,
    BODY      = 2'd2
  } phase_t;

  // Framer state as the predictor tracks it
  phase_t     phase;
  logic [2:0] live_roots;
  logic [1:0] root_sel;
  int         tag_pos;
  int         frame_pos;

  // Byte reports predicted but not yet seen on the output
  result_t    byte_reports_q[$];
  result_t    want;
  result_t    seen;
  bit         bad;

  initial begin
    fail_count  = 0;
    outstanding = 0;
  end

  function automatic int name_len(input logic [1:0] kind);
    return (kind == RK_REQUEST) ? 7 : 5;
  endfunction

  // Byte i of the root name; string literals are right aligned in the vector
  function automatic logic [7:0] name_char(input logic [1:0] kind, input int i);
    logic [55:0] txt;
    case (kind)
      RK_REQUEST: txt = "Request";
      RK_REPLY:   txt = "Reply";
      default:    txt = "Event";
    endcase
    return txt[(name_len(kind) - 1 - i) * 8 +: 8];
  endfunction

  function automatic bit is_blank(input logic [7:0] b);
    return b == CH_SPACE || b == CH_TAB || b == CH_CR || b == CH_LF;
  endfunction

  function automatic bit ends_name(input logic [7:0] b);
    return b == CH_SPACE || b == CH_GT || b == CH_CR || b == CH_LF;
  endfunction

  // Byte m of "</name>"
  function automatic logic [7:0] tag_char(input logic [1:0] kind, input int m);
    if (m == 0) return CH_LT;
    if (m == 1) return CH_SLASH;
    if (m < name_len(kind) + 2) return name_char(kind, m - 2);
    return CH_GT;
  endfunction

  task automatic clear_frame();
    phase      = SKIPPING;
    live_roots = 3'b111;
    root_sel   = RK_REQUEST;
    tag_pos    = 0;
    frame_pos  = 0;
  endtask

  // One byte through the framer: update state, produce its report
  task automatic track_frame(input logic [7:0] b, input logic rs, output result_t r);
    int         nxt;
    int         m;
    int         len;
    int         found;
    logic [2:0] live;
    r.byte_out     = b;
    r.status       = ST_OUTSIDE;
    r.root_kind    = RK_REQUEST;
    r.frame_offset = '0;
    if (rs) clear_frame();

    if (phase == ROOT_NAME || phase == BODY) begin
      nxt = frame_pos + 1;
      if (nxt >= OFFSET_LIMIT) begin
        // frame ran past the offset range
        r.status       = ST_ERROR;
        r.root_kind    = (phase == BODY) ? root_sel : RK_REQUEST;
        r.frame_offset = LAST_OFFSET;
        clear_frame();
      end else if (phase == ROOT_NAME) begin
        // narrow the root candidates by one more name byte
        live           = '0;
        found          = -1;
        frame_pos      = nxt;
        r.frame_offset = 16'(nxt);
        for (int k = 0; k < 3; k++) begin
          len = name_len(2'(k));
          if (live_roots[k]) begin
            if (nxt <= len) begin
              if (b == name_char(2'(k), nxt - 1)) live[k] = 1'b1;
            end else if (nxt == len + 1 && ends_name(b) && found < 0) begin
              found = k;
            end
          end
        end
        if (found >= 0) begin
          phase       = BODY;
          root_sel    = 2'(found);
          tag_pos     = 0;
          live_roots  = 3'b001 << found;
          r.status    = ST_FRAME;
          r.root_kind = root_sel;
        end else if (live == 3'b000) begin
          r.status = ST_ERROR;
          clear_frame();
        end else begin
          live_roots = live;
          r.status   = ST_FRAME;
        end
      end else begin
        // body: hunt for the matching closing tag
        len            = name_len(root_sel);
        m              = tag_pos;
        frame_pos      = nxt;
        r.frame_offset = 16'(nxt);
        r.root_kind    = root_sel;
        if (m > len + 2) m = 0;
        if (b == tag_char(root_sel, m)) begin
          m++;
          if (m == len + 3) begin
            r.status = ST_LAST;
            clear_frame();
          end else begin
            r.status = ST_FRAME;
            tag_pos  = m;
          end
        end else begin
          tag_pos  = (b == CH_LT) ? 1 : 0;
          r.status = ST_FRAME;
        end
      end
    end else begin
      // skipping whitespace before a frame
      phase = SKIPPING;
      if (is_blank(b)) begin
        r.status = ST_OUTSIDE;
      end else if (b == CH_LT) begin
        phase      = ROOT_NAME;
        live_roots = 3'b111;
        root_sel   = RK_REQUEST;
        tag_pos    = 0;
        frame_pos  = 0;
        r.status   = ST_FRAME;
      end else begin
        r.status = ST_ERROR;
        clear_frame();
      end
    end
  endtask

  task automatic check_field(input string field, input int exp_v, input int act_v,
                             inout bit flag);
    if (exp_v != act_v) begin
      $error("%s: expected %0d, actual %0d", field, exp_v, act_v);
      flag = 1'b1;
    end
  endtask

  // Predict on every input transaction, compare on every output transaction
  always @(posedge clk) begin
    if (!rst_n) begin
      clear_frame();
      byte_reports_q.delete();
    end else begin
      if (in_tvalid && in_tready) begin
        track_frame(in_tdata, in_tuser[0], want);
        byte_reports_q.push_back(want);
      end
      if (out_tvalid && out_tready) begin
        seen = {out_tdata[23:8], out_tuser[3:2], out_tuser[1:0], out_tdata[7:0]};
        if (byte_reports_q.size() == 0) begin
          $error("report transaction with no byte pending: byte_out %0d", seen.byte_out);
          fail_count++;
        end else begin
          want = byte_reports_q.pop_front();
          bad  = 1'b0;
          check_field("byte_out", want.byte_out, seen.byte_out, bad);
          check_field("status", want.status, seen.status, bad);
          check_field("root_kind", want.root_kind, seen.root_kind, bad);
          check_field("frame_offset", want.frame_offset, seen.frame_offset, bad);
          if (bad) fail_count++;
        end
      end
    end
    outstanding <= byte_reports_q.size();
  end

endmodule

// ----- tb/tb_xml_root_tag_framer.sv -----
module tb_xml_root_tag_framer;
  import xrtf_pkg::*;

  localparam int STALL_MAX      = 13;
  localparam int WATCHDOG_LIMIT = 400;
  localparam int DRAIN_CYCLES   = 20;
  localparam int RANDOM_BYTES   = 1450;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;   // [7:0] data_byte
  logic [0:0]  in_tuser;   // [0] restart
  logic        out_tvalid;
  logic        out_tready;
  logic [23:0] out_tdata;  // [7:0] byte_out, [23:8] frame_offset
  logic [3:0]  out_tuser;  // [1:0] status, [3:2] root_kind

  int fail_total;
  int pending;
  int bytes_sent   = 0;
  int quiet_cycles = 0;
  bit idling_on    = 1'b1;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  xml_root_tag_framer u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  xrtf_frame_checker u_frame_chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .fail_count  (fail_total),
    .outstanding (pending)
  );

  // Watchdog: too long without any transaction on either channel
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // Result side: random stall before each report transaction
  initial begin
    int stall;
    out_tready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      stall = idling_on ? $urandom_range(STALL_MAX, 0) : 0;
      if (stall > 0) begin
        @(negedge clk);
        out_tready <= 1'b0;
        repeat (stall - 1) @(negedge clk);
      end
      @(negedge clk);
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  // One byte transaction, with a random gap ahead of it
  task automatic send_byte(input logic [7:0] b, input logic rs);
    int gap;
    gap = idling_on ? $urandom_range(STALL_MAX, 0) : 0;
    if (gap > 0) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tuser  <= rs;
    do @(posedge clk); while (!in_tready);
    bytes_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], 1'b0);
  endtask

  function automatic string root_name(input logic [1:0] kind);
    case (kind)
      RK_REQUEST: return "Request";
      RK_REPLY:   return "Reply";
      default:    return "Event";
    endcase
  endfunction

  function automatic logic [7:0] blank_char(input int i);
    case (i)
      0:       return CH_SPACE;
      1:       return CH_TAB;
      2:       return CH_CR;
      default: return CH_LF;
    endcase
  endfunction

  function automatic logic [7:0] name_end_char(input int i);
    case (i)
      0:       return CH_SPACE;
      1:       return CH_GT;
      2:       return CH_CR;
      default: return CH_LF;
    endcase
  endfunction

  // Body bytes with stray '<' and partial closing tags mixed in
  task automatic send_body();
    int    len;
    int    pick;
    int    cut;
    string other;
    len = ($urandom_range(19, 0) == 0) ? $urandom_range(600, 200) : $urandom_range(20, 0);
    for (int i = 0; i < len; i++) begin
      pick = $urandom_range(15, 0);
      if (pick == 0) begin
        send_byte(CH_LT, 1'b0);
      end else if (pick == 1) begin
        other = root_name(2'($urandom_range(2, 0)));
        cut   = $urandom_range(other.len(), 0);
        send_byte(CH_LT, 1'b0);
        send_byte(CH_SLASH, 1'b0);
        for (int j = 0; j < cut; j++) send_byte(other[j], 1'b0);
      end else begin
        send_byte(8'($urandom_range(255, 0)), 1'b0);
      end
    end
  endtask

  initial begin
    int         choice;
    int         cut;
    int         random_goal;
    logic [1:0] kind;
    string      nm;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = '0;
    rst_n     = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: whitespace, bad start bytes, unknown root, restart mid-root
    send_byte(CH_SPACE, 1'b0);
    send_byte(CH_TAB, 1'b0);
    send_byte(CH_CR, 1'b0);
    send_byte(CH_LF, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_text("<Rx");
    send_text("<E");
    send_byte(CH_LT, 1'b1);
    send_text("Reply></Reply>");

    // Random: mostly well-formed frames, plus broken roots, noise, restarts
    random_goal = RANDOM_BYTES;
    while (bytes_sent < random_goal) begin
      choice    = $urandom_range(99, 0);
      idling_on = ($urandom_range(7, 0) != 0);
      kind      = 2'($urandom_range(2, 0));
      nm        = root_name(kind);
      if (choice < 70) begin
        repeat ($urandom_range(3, 0)) send_byte(blank_char($urandom_range(3, 0)), 1'b0);
        send_byte(CH_LT, 1'b0);
        send_text(nm);
        send_byte(name_end_char($urandom_range(3, 0)), 1'b0);
        send_body();
        send_byte(CH_LT, 1'b0);
        send_byte(CH_SLASH, 1'b0);
        send_text(nm);
        send_byte(CH_GT, 1'b0);
      end else if (choice < 80) begin
        // root name that goes wrong somewhere
        cut = $urandom_range(nm.len(), 0);
        send_byte(CH_LT, 1'b0);
        for (int i = 0; i < cut; i++) send_byte(nm[i], 1'b0);
        send_byte(8'($urandom_range(255, 0)), 1'b0);
      end else if (choice < 90) begin
        repeat ($urandom_range(10, 1))
          send_byte(8'($urandom_range(255, 0)), ($urandom_range(7, 0) == 0));
      end else begin
        // frame abandoned by a restart
        send_byte(CH_LT, 1'b0);
        send_text(nm);
        send_byte(name_end_char($urandom_range(3, 0)), 1'b0);
        send_body();
        send_byte(8'($urandom_range(255, 0)), 1'b1);
      end
    end
    idling_on = 1'b1;

    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (fail_total == 0 && pending == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule

// ----- filelist.f -----
src/xrtf_pkg.sv
src/xrtf_in_reg.sv
src/xrtf_parser.sv
src/xrtf_out_reg.sv
src/xml_root_tag_framer.sv
tb/xrtf_frame_checker.sv
tb/tb_xml_root_tag_framer.sv
